### hw/rtl/ccpf_pkg.sv
package ccpf_pkg;

  // Field and register widths fixed by the block definition
  localparam int BOX_W      = 31;
  localparam int AXES_W     = 3;
  localparam int CUT_W      = 63;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 63;
  localparam int CHARGE_W   = 32;

  // Datapath widths
  localparam int MAG_W  = 32;   // wrapped |r| per axis when in range
  localparam int SQ_W   = 64;   // |r|^2 per axis
  localparam int QQ_W   = 64;   // qi*qj, Q32.32 signed
  localparam int QMAG_W = 63;   // |qi*qj|
  localparam int K_W    = 32;   // 1/(4*pi), unsigned Q0.32
  localparam int KQ_W   = 91;   // K*|qq|
  localparam int NUM_W  = 123;  // K*|qq|*|r_d|
  localparam int R2_W   = 64;
  localparam int ROOT_W = 64;
  localparam int DEN_W  = 95;   // r2*s
  localparam int DVS_W  = 103;  // r2*s*256
  localparam int CNT_W  = 7;

  localparam logic [K_W-1:0]    INV_4PI_Q32 = 32'd341782638;
  localparam logic [BOX_W-1:0]  BOX_RESET   = 31'd65536;
  localparam logic [ROOT_W-1:0] ROOT_BIT0   = 64'h4000_0000_0000_0000;
  localparam logic [CNT_W-1:0]  ROOT_LAST   = 7'd31;
  localparam logic [CNT_W-1:0]  MUL_LAST    = 7'd31;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BOX_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_Z    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PERIODIC = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CUTOFF   = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WRAP,
    ST_SQUARE,
    ST_SUM,
    ST_ROOT,
    ST_MULI,
    ST_MUL,
    ST_DIVI,
    ST_DIV,
    ST_ACC
  } state_t;

  typedef struct packed {
    logic load;
    logic wrap;
    logic square;
    logic sum;
    logic root_step;
    logic mul_init;
    logic mul_step;
    logic div_init;
    logic div_step;
    logic acc;
  } dp_cmd_t;

  typedef struct packed {
    logic hit;
    logic out_full;
  } dp_sts_t;

endpackage

### hw/rtl/ccpf_if.sv
interface ccpf_in_if #(parameter int CW = 32);
  logic                                 valid;
  logic                                 ready;
  logic signed [CW-1:0]                 target_x;
  logic signed [CW-1:0]                 target_y;
  logic signed [CW-1:0]                 target_z;
  logic signed [ccpf_pkg::CHARGE_W-1:0] target_charge;
  logic signed [CW-1:0]                 source_x;
  logic signed [CW-1:0]                 source_y;
  logic signed [CW-1:0]                 source_z;
  logic signed [ccpf_pkg::CHARGE_W-1:0] source_charge;
  logic                                 first_source;
  logic                                 last_source;

  modport source (
    output valid, target_x, target_y, target_z, target_charge,
           source_x, source_y, source_z, source_charge, first_source, last_source,
    input  ready
  );
  modport sink (
    input  valid, target_x, target_y, target_z, target_charge,
           source_x, source_y, source_z, source_charge, first_source, last_source,
    output ready
  );
endinterface

interface ccpf_out_if #(parameter int FW = 48);
  logic                 valid;
  logic                 ready;
  logic signed [FW-1:0] pair_fx;
  logic signed [FW-1:0] pair_fy;
  logic signed [FW-1:0] pair_fz;
  logic                 in_range;
  logic signed [FW-1:0] total_fx;
  logic signed [FW-1:0] total_fy;
  logic signed [FW-1:0] total_fz;
  logic                 total_valid;

  modport source (
    output valid, pair_fx, pair_fy, pair_fz, in_range,
           total_fx, total_fy, total_fz, total_valid,
    input  ready
  );
  modport sink (
    input  valid, pair_fx, pair_fy, pair_fz, in_range,
           total_fx, total_fy, total_fz, total_valid,
    output ready
  );
endinterface

### hw/rtl/ccpf_dp.sv
module ccpf_dp #(
  parameter int CW = 32,
  parameter int FW = 48
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // configuration
  input  logic                                   cfg_we,
  input  logic [ccpf_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [ccpf_pkg::CFG_DATA_W-1:0]        cfg_data,
  // control
  input  ccpf_pkg::dp_cmd_t                      cmd,
  output ccpf_pkg::dp_sts_t                      sts,
  // input item
  input  logic signed [CW-1:0]                   target_x,
  input  logic signed [CW-1:0]                   target_y,
  input  logic signed [CW-1:0]                   target_z,
  input  logic signed [ccpf_pkg::CHARGE_W-1:0]   target_charge,
  input  logic signed [CW-1:0]                   source_x,
  input  logic signed [CW-1:0]                   source_y,
  input  logic signed [CW-1:0]                   source_z,
  input  logic signed [ccpf_pkg::CHARGE_W-1:0]   source_charge,
  input  logic                                   first_source,
  input  logic                                   last_source,
  // result item
  input  logic                                   out_ready,
  output logic                                   out_valid,
  output logic signed [FW-1:0]                   pair_fx,
  output logic signed [FW-1:0]                   pair_fy,
  output logic signed [FW-1:0]                   pair_fz,
  output logic                                   in_range,
  output logic signed [FW-1:0]                   total_fx,
  output logic signed [FW-1:0]                   total_fy,
  output logic signed [FW-1:0]                   total_fz,
  output logic                                   total_valid
);

  localparam int WW    = (CW + 4 > 34) ? CW + 4 : 34;
  localparam int DSH_W = ccpf_pkg::DVS_W + FW;
  localparam logic signed [FW-1:0] POS_MAX = {1'b0, {(FW-1){1'b1}}};
  localparam logic signed [FW-1:0] NEG_MIN = {1'b1, {(FW-1){1'b0}}};

  // configuration registers
  logic [ccpf_pkg::BOX_W-1:0]  box_r [3];
  logic [ccpf_pkg::AXES_W-1:0] periodic_r;
  logic [ccpf_pkg::CUT_W-1:0]  cut_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_r[0]   <= ccpf_pkg::BOX_RESET;
      box_r[1]   <= ccpf_pkg::BOX_RESET;
      box_r[2]   <= ccpf_pkg::BOX_RESET;
      periodic_r <= '0;
      cut_r      <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        ccpf_pkg::REG_BOX_X:    box_r[0]   <= cfg_data[ccpf_pkg::BOX_W-1:0];
        ccpf_pkg::REG_BOX_Y:    box_r[1]   <= cfg_data[ccpf_pkg::BOX_W-1:0];
        ccpf_pkg::REG_BOX_Z:    box_r[2]   <= cfg_data[ccpf_pkg::BOX_W-1:0];
        ccpf_pkg::REG_PERIODIC: periodic_r <= cfg_data[ccpf_pkg::AXES_W-1:0];
        ccpf_pkg::REG_CUTOFF:   cut_r      <= cfg_data[ccpf_pkg::CUT_W-1:0];
        default: ;
      endcase
    end
  end

  // captured item
  logic signed [CW-1:0]                 tgt_r [3];
  logic signed [CW-1:0]                 src_r [3];
  logic signed [ccpf_pkg::CHARGE_W-1:0] qi_r, qj_r;
  logic                                 first_r, last_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tgt_r[0] <= target_x;
      tgt_r[1] <= target_y;
      tgt_r[2] <= target_z;
      src_r[0] <= source_x;
      src_r[1] <= source_y;
      src_r[2] <= source_z;
      qi_r     <= target_charge;
      qj_r     <= source_charge;
      first_r  <= first_source;
      last_r   <= last_source;
    end
  end

  // minimum-image wrap and magnitude per axis
  logic signed [WW-1:0] dif [3];
  logic signed [WW-1:0] r1 [3];
  logic signed [WW-1:0] rw [3];
  logic signed [WW-1:0] bs [3];
  logic [WW-1:0]        rmg [3];
  logic                 far_c;

  always_comb begin
    far_c = 1'b0;
    for (int d = 0; d < 3; d++) begin
      bs[d]  = $signed({{(WW-ccpf_pkg::BOX_W){1'b0}}, box_r[d]});
      dif[d] = WW'(tgt_r[d]) - WW'(src_r[d]);
      r1[d]  = (periodic_r[d] && ((dif[d] <<< 1) > bs[d])) ? dif[d] - bs[d] : dif[d];
      rw[d]  = (periodic_r[d] && ((r1[d] <<< 1) < -bs[d])) ? r1[d] + bs[d] : r1[d];
      rmg[d] = rw[d][WW-1] ? $unsigned(-rw[d]) : $unsigned(rw[d]);
      far_c  = far_c | (|rmg[d][WW-1:ccpf_pkg::MAG_W]);
    end
  end

  logic [ccpf_pkg::MAG_W-1:0]   rmag_r [3];
  logic                         rneg_r [3];
  logic                         far_r;
  logic signed [ccpf_pkg::QQ_W-1:0] qq_r;

  always_ff @(posedge clk) begin
    if (cmd.wrap) begin
      for (int d = 0; d < 3; d++) begin
        rmag_r[d] <= rmg[d][ccpf_pkg::MAG_W-1:0];
        rneg_r[d] <= rw[d][WW-1];
      end
      far_r <= far_c;
      qq_r  <= qi_r * qj_r;
    end
  end

  // squares and charge magnitude
  logic [ccpf_pkg::SQ_W-1:0]   sq_r [3];
  logic [ccpf_pkg::QMAG_W-1:0] qmag_r;
  logic                        qneg_r;
  logic [ccpf_pkg::QQ_W-1:0]   qabs;

  assign qabs = qq_r[ccpf_pkg::QQ_W-1] ? $unsigned(-qq_r) : $unsigned(qq_r);

  always_ff @(posedge clk) begin
    if (cmd.square) begin
      for (int d = 0; d < 3; d++) begin
        sq_r[d] <= ccpf_pkg::SQ_W'(rmag_r[d]) * ccpf_pkg::SQ_W'(rmag_r[d]);
      end
      qmag_r <= qabs[ccpf_pkg::QMAG_W-1:0];
      qneg_r <= qq_r[ccpf_pkg::QQ_W-1];
    end
  end

  // saturating r2 and the range test
  logic [ccpf_pkg::SQ_W+1:0] sum3;
  logic [ccpf_pkg::R2_W-1:0] r2_c;
  logic                      hit_c;

  assign sum3  = {2'b00, sq_r[0]} + {2'b00, sq_r[1]} + {2'b00, sq_r[2]};
  assign r2_c  = (|sum3[ccpf_pkg::SQ_W+1:ccpf_pkg::SQ_W]) ? '1 : sum3[ccpf_pkg::SQ_W-1:0];
  assign hit_c = !far_r && (r2_c != '0) && (r2_c < {1'b0, cut_r});

  logic [ccpf_pkg::R2_W-1:0]   r2_r;
  logic                        hit_r;
  // square root unit
  logic [ccpf_pkg::ROOT_W-1:0] rt_rem_r, rt_root_r, rt_bit_r, rt_try;
  // K*|qq| shift-add unit
  logic [ccpf_pkg::KQ_W-1:0]   kq_acc_r, kq_a_r;
  logic [ccpf_pkg::K_W-1:0]    kq_b_r;

  assign rt_try = rt_root_r + rt_bit_r;

  always_ff @(posedge clk) begin
    if (cmd.sum) begin
      r2_r      <= r2_c;
      hit_r     <= hit_c;
      rt_rem_r  <= r2_c;
      rt_root_r <= '0;
      rt_bit_r  <= ccpf_pkg::ROOT_BIT0;
      kq_acc_r  <= '0;
      kq_a_r    <= ccpf_pkg::KQ_W'(qmag_r);
      kq_b_r    <= ccpf_pkg::INV_4PI_Q32;
    end else if (cmd.root_step) begin
      // one result bit per step
      if (rt_rem_r >= rt_try) begin
        rt_rem_r  <= rt_rem_r - rt_try;
        rt_root_r <= (rt_root_r >> 1) + rt_bit_r;
      end else begin
        rt_root_r <= rt_root_r >> 1;
      end
      rt_bit_r <= rt_bit_r >> 2;
      if (kq_b_r[0]) kq_acc_r <= kq_acc_r + kq_a_r;
      kq_a_r <= kq_a_r << 1;
      kq_b_r <= kq_b_r >> 1;
    end
  end

  // denominator r2*s and numerators K*|qq|*|r_d|, shift-add
  logic [ccpf_pkg::DEN_W-1:0] den_acc_r, den_a_r;
  logic [ccpf_pkg::MAG_W-1:0] den_b_r;
  logic [ccpf_pkg::NUM_W-1:0] nm_acc_r [3];
  logic [ccpf_pkg::NUM_W-1:0] nm_a_r;
  logic [ccpf_pkg::MAG_W-1:0] nm_b_r [3];

  always_ff @(posedge clk) begin
    if (cmd.mul_init) begin
      den_acc_r <= '0;
      den_a_r   <= ccpf_pkg::DEN_W'(r2_r);
      den_b_r   <= rt_root_r[ccpf_pkg::MAG_W-1:0];
      nm_a_r    <= ccpf_pkg::NUM_W'(kq_acc_r);
      for (int d = 0; d < 3; d++) begin
        nm_acc_r[d] <= '0;
        nm_b_r[d]   <= rmag_r[d];
      end
    end else if (cmd.mul_step) begin
      if (den_b_r[0]) den_acc_r <= den_acc_r + den_a_r;
      den_a_r <= den_a_r << 1;
      den_b_r <= den_b_r >> 1;
      nm_a_r  <= nm_a_r << 1;
      for (int d = 0; d < 3; d++) begin
        if (nm_b_r[d][0]) nm_acc_r[d] <= nm_acc_r[d] + nm_a_r;
        nm_b_r[d] <= nm_b_r[d] >> 1;
      end
    end
  end

  // restoring division, three lanes sharing one shifted divisor
  logic [ccpf_pkg::DVS_W-1:0] dvs;
  logic [DSH_W-1:0]           dsh_r;
  logic [ccpf_pkg::NUM_W-1:0] rem_r [3];
  logic [FW-1:0]              q_r [3];
  logic                       ovf_r [3];

  assign dvs = {den_acc_r, 8'h00};

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      dsh_r <= DSH_W'(dvs) << (FW - 1);
      for (int d = 0; d < 3; d++) begin
        ovf_r[d] <= DSH_W'(nm_acc_r[d]) >= (DSH_W'(dvs) << FW);
        rem_r[d] <= nm_acc_r[d];
        q_r[d]   <= '0;
      end
    end else if (cmd.div_step) begin
      dsh_r <= dsh_r >> 1;
      for (int d = 0; d < 3; d++) begin
        if (DSH_W'(rem_r[d]) >= dsh_r) begin
          rem_r[d] <= rem_r[d] - dsh_r[ccpf_pkg::NUM_W-1:0];
          q_r[d]   <= {q_r[d][FW-2:0], 1'b1};
        end else begin
          q_r[d]   <= {q_r[d][FW-2:0], 1'b0};
        end
      end
    end
  end

  // force saturation, sign and accumulation
  logic [FW-1:0]        lim [3];
  logic [FW-1:0]        msat [3];
  logic signed [FW-1:0] pf [3];
  logic signed [FW-1:0] base [3];
  logic signed [FW:0]   ssum [3];
  logic signed [FW-1:0] nsum [3];
  logic signed [FW-1:0] sum_r [3];
  logic                 neg [3];

  always_comb begin
    for (int d = 0; d < 3; d++) begin
      neg[d]  = qneg_r ^ rneg_r[d];
      lim[d]  = $unsigned(POS_MAX) + FW'(neg[d]);
      msat[d] = (ovf_r[d] || (q_r[d] > lim[d])) ? lim[d] : q_r[d];
      pf[d]   = !hit_r ? '0 : (neg[d] ? $signed(-msat[d]) : $signed(msat[d]));
      base[d] = first_r ? '0 : sum_r[d];
      ssum[d] = (FW+1)'(base[d]) + (FW+1)'(pf[d]);
      if (ssum[d][FW] != ssum[d][FW-1]) begin
        nsum[d] = ssum[d][FW] ? NEG_MIN : POS_MAX;
      end else begin
        nsum[d] = ssum[d][FW-1:0];
      end
      if (!hit_r) nsum[d] = base[d];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int d = 0; d < 3; d++) sum_r[d] <= '0;
    end else if (cmd.acc) begin
      for (int d = 0; d < 3; d++) sum_r[d] <= nsum[d];
    end
  end

  // output register
  logic                 out_valid_r;
  logic signed [FW-1:0] out_pf_r [3];
  logic signed [FW-1:0] out_tot_r [3];
  logic                 out_range_r, out_tv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      if (cmd.acc) out_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc) begin
      for (int d = 0; d < 3; d++) begin
        out_pf_r[d]  <= pf[d];
        out_tot_r[d] <= last_r ? nsum[d] : '0;
      end
      out_range_r <= hit_r;
      out_tv_r    <= last_r;
    end
  end

  assign sts.hit      = hit_c;
  assign sts.out_full = out_valid_r && !out_ready;

  assign out_valid   = out_valid_r;
  assign pair_fx     = out_pf_r[0];
  assign pair_fy     = out_pf_r[1];
  assign pair_fz     = out_pf_r[2];
  assign in_range    = out_range_r;
  assign total_fx    = out_tot_r[0];
  assign total_fy    = out_tot_r[1];
  assign total_fz    = out_tot_r[2];
  assign total_valid = out_tv_r;

endmodule

### hw/rtl/ccpf_ctrl.sv
module ccpf_ctrl #(
  parameter int FW = 48
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ccpf_pkg::dp_sts_t sts,
  output ccpf_pkg::dp_cmd_t cmd
);

  localparam logic [ccpf_pkg::CNT_W-1:0] DIV_LAST = ccpf_pkg::CNT_W'(FW - 1);

  ccpf_pkg::state_t            state_r, state_nxt;
  logic [ccpf_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ccpf_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // sequencing of the datapath
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = '0;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ccpf_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ccpf_pkg::ST_WRAP;
        end
      end
      ccpf_pkg::ST_WRAP: begin
        cmd.wrap  = 1'b1;
        state_nxt = ccpf_pkg::ST_SQUARE;
      end
      ccpf_pkg::ST_SQUARE: begin
        cmd.square = 1'b1;
        state_nxt  = ccpf_pkg::ST_SUM;
      end
      ccpf_pkg::ST_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = sts.hit ? ccpf_pkg::ST_ROOT : ccpf_pkg::ST_ACC;
      end
      ccpf_pkg::ST_ROOT: begin
        cmd.root_step = 1'b1;
        cnt_nxt       = cnt_r + 1'b1;
        if (cnt_r == ccpf_pkg::ROOT_LAST) state_nxt = ccpf_pkg::ST_MULI;
      end
      ccpf_pkg::ST_MULI: begin
        cmd.mul_init = 1'b1;
        state_nxt    = ccpf_pkg::ST_MUL;
      end
      ccpf_pkg::ST_MUL: begin
        cmd.mul_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == ccpf_pkg::MUL_LAST) state_nxt = ccpf_pkg::ST_DIVI;
      end
      ccpf_pkg::ST_DIVI: begin
        cmd.div_init = 1'b1;
        state_nxt    = ccpf_pkg::ST_DIV;
      end
      ccpf_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == DIV_LAST) state_nxt = ccpf_pkg::ST_ACC;
      end
      ccpf_pkg::ST_ACC: begin
        // wait for the previous result to leave the output register
        if (!sts.out_full) begin
          cmd.acc   = 1'b1;
          state_nxt = ccpf_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ccpf_pkg::ST_IDLE;
    endcase
  end

  a_root_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ccpf_pkg::ST_ROOT && cnt_r == ccpf_pkg::ROOT_LAST)
      |=> state_r == ccpf_pkg::ST_MULI)
    else $error("root loop did not end after its last step");

  a_div_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ccpf_pkg::ST_DIV) |-> cnt_r <= DIV_LAST)
    else $error("divider counter ran past its last step");

  a_miss_skip: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ccpf_pkg::ST_SUM && !sts.hit) |=> state_r == ccpf_pkg::ST_ACC)
    else $error("out of range pair entered the force path");

  a_acc_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ccpf_pkg::ST_ACC && sts.out_full) |=> state_r == ccpf_pkg::ST_ACC)
    else $error("result written while output register full");

endmodule

### hw/rtl/cutoff_coulomb_pair_force_top.sv
// Cutoff Coulomb pair force with minimum-image wrap.
// in_ch (valid/ready) carries one target/source pair per transfer; out_ch
// carries one result per pair: the pair force, in_range, and on the last
// source of a run the saturated force sum with total_valid set.
// cfg_we/cfg_index/cfg_data write box_x, box_y, box_z, periodic_axes and
// cutoff_squared (indexes 0..4); other indexes are ignored. The user must
// write them only while the block is idle; the block does not enforce it.
// An in-range pair passes through wrap, square, sum, the square root, the
// multiply set-up and multiplies, the divider set-up and divider, and then
// accumulate before reaching out_ch; an out-of-range pair goes from sum
// straight to accumulate. One pair is worked on at a time and the next
// transfer can be taken the cycle after a result is written.
// The in-range path runs the 32-step square root, the 32-step shift-add
// multiplies and the FORCE_WIDTH-step divider.
// Reset (synchronous, rst_n low) restores the register defaults, clears the
// force sums and empties the output register.
// When out_ch stalls, a finished result waits in the output register; the
// block still takes the next pair and holds its result until the register
// is free.
module cutoff_coulomb_pair_force_top #(
  parameter int COORD_WIDTH = 32,
  parameter int FORCE_WIDTH = 48
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [ccpf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ccpf_pkg::CFG_DATA_W-1:0]   cfg_data,
  ccpf_in_if.sink                           in_ch,
  ccpf_out_if.source                        out_ch
);

  ccpf_pkg::dp_cmd_t cmd;
  ccpf_pkg::dp_sts_t sts;

  ccpf_ctrl #(.FW(FORCE_WIDTH)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ccpf_dp #(.CW(COORD_WIDTH), .FW(FORCE_WIDTH)) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .cmd           (cmd),
    .sts           (sts),
    .target_x      (in_ch.target_x),
    .target_y      (in_ch.target_y),
    .target_z      (in_ch.target_z),
    .target_charge (in_ch.target_charge),
    .source_x      (in_ch.source_x),
    .source_y      (in_ch.source_y),
    .source_z      (in_ch.source_z),
    .source_charge (in_ch.source_charge),
    .first_source  (in_ch.first_source),
    .last_source   (in_ch.last_source),
    .out_ready     (out_ch.ready),
    .out_valid     (out_ch.valid),
    .pair_fx       (out_ch.pair_fx),
    .pair_fy       (out_ch.pair_fy),
    .pair_fz       (out_ch.pair_fz),
    .in_range      (out_ch.in_range),
    .total_fx      (out_ch.total_fx),
    .total_fy      (out_ch.total_fy),
    .total_fz      (out_ch.total_fz),
    .total_valid   (out_ch.total_valid)
  );

endmodule
